FILE: rtl/csd_pkg.sv
package csd_pkg;

  // fixed field widths
  localparam int CylW     = 16;
  localparam int SizeW    = 17;
  localparam int MoveW    = 18;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DISK_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_HEAD  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SWEEP_RIGHT = 2'd2;

  // result kinds
  localparam logic KIND_SERVED  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_SWEEP_A,
    ST_SWEEP_B,
    ST_EMIT,
    ST_SUMMARY
  } csd_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_req;
    logic start;
    logic scan_step;
    logic sweep_a;
    logic sweep_b;
    logic emit;
    logic summary;
  } csd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic scan_last;
    logic best_cls;
    logic swept;
    logic emitted_all;
    logic emit_last;
    logic out_free;
  } csd_stat_t;

endpackage

FILE: rtl/csd_ifs.sv
interface csd_req_if import csd_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CylW-1:0] request_cylinder;
  logic            last_request;

  modport source (output valid, output request_cylinder, output last_request, input ready);
  modport sink (input valid, input request_cylinder, input last_request, output ready);
endinterface

interface csd_res_if import csd_pkg::*;;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [CylW-1:0]  served_cylinder;
  logic [MoveW-1:0] total_movement;
  logic             end_of_run;

  modport source (output valid, output result_kind, output served_cylinder,
                  output total_movement, output end_of_run, input ready);
  modport sink (input valid, input result_kind, input served_cylinder,
                input total_movement, input end_of_run, output ready);
endinterface

interface csd_cfg_if import csd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/csd_ctrl.sv
module csd_ctrl import csd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  csd_stat_t stat,
  output csd_cmd_t  cmd
);

  csd_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (stat.in_valid && stat.in_last) state_nxt = ST_START;
      end
      ST_START: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.best_cls && !stat.swept) state_nxt = ST_SWEEP_A;
        else state_nxt = ST_EMIT;
      end
      ST_SWEEP_A: state_nxt = ST_SWEEP_B;
      ST_SWEEP_B: begin
        if (stat.emitted_all) state_nxt = ST_SUMMARY;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          if (!stat.emit_last) state_nxt = ST_SCAN;
          else if (stat.swept) state_nxt = ST_SUMMARY;
          else state_nxt = ST_SWEEP_A;
        end
      end
      ST_SUMMARY: begin
        if (stat.out_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_LOAD:    cmd.take_req  = 1'b1;
      ST_START:   cmd.start     = 1'b1;
      ST_SCAN:    cmd.scan_step = 1'b1;
      ST_SWEEP_A: cmd.sweep_a   = 1'b1;
      ST_SWEEP_B: cmd.sweep_b   = 1'b1;
      ST_EMIT:    cmd.emit      = stat.out_free;
      ST_SUMMARY: cmd.summary   = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

FILE: rtl/csd_dp.sv
module csd_dp import csd_pkg::*; #(
  parameter int MAX_REQUESTS  = 32,
  parameter int CYLINDER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  csd_cmd_t            cmd,
  output csd_stat_t           stat,
  input  logic                in_valid,
  input  logic [CylW-1:0]     in_cyl,
  input  logic                in_last,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_kind,
  output logic [CylW-1:0]     out_cyl,
  output logic [MoveW-1:0]    out_move,
  output logic                out_end
);

  localparam int AddrW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CntW  = $clog2(MAX_REQUESTS + 1);
  localparam int KeyW  = CylW + 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_REQUESTS);
  localparam logic [SizeW-1:0] SizeCap = (CYLINDER_BITS >= SizeW) ?
                                         {SizeW{1'b1}} : (SizeW'(1) << CYLINDER_BITS);
  localparam logic [CylW-1:0] CylMask = (CYLINDER_BITS >= CylW) ?
                                        {CylW{1'b1}} : CylW'((32'd1 << CYLINDER_BITS) - 1);

  // configuration registers
  logic [SizeW-1:0] disk_size_r;
  logic [CylW-1:0]  start_head_r;
  logic             sweep_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r   <= SizeW'(200);
      start_head_r  <= '0;
      sweep_right_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DISK_SIZE:   disk_size_r   <= cfg_data;
        CFG_START_HEAD:  start_head_r  <= cfg_data[CylW-1:0];
        CFG_SWEEP_RIGHT: sweep_right_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective disk size and highest cylinder
  logic [SizeW-1:0] size_eff, top;
  always_comb begin
    size_eff = disk_size_r;
    if (size_eff == '0) size_eff = SizeW'(1);
    if (size_eff > SizeCap) size_eff = SizeCap;
  end
  assign top = size_eff - SizeW'(1);

  // clamp incoming request and start head
  logic [CylW-1:0] cyl_m, cyl_clamp, head_clamp;
  assign cyl_m      = in_cyl & CylMask;
  assign cyl_clamp  = ({1'b0, cyl_m} > top) ? top[CylW-1:0] : cyl_m;
  assign head_clamp = ({1'b0, start_head_r} > top) ? top[CylW-1:0] : start_head_r;

  logic in_fire;
  assign in_fire = cmd.take_req & in_valid;

  // request store and fill count
  logic [CylW-1:0] mem [MAX_REQUESTS];
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] scan_idx_r;
  logic [CylW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (in_fire && (count_r < CntMax)) mem[count_r[AddrW-1:0]] <= cyl_clamp;
    if (cmd.scan_step) rd_data_r <= mem[scan_idx_r[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.summary) begin
      count_r <= '0;
    end else if (in_fire && (count_r < CntMax)) begin
      count_r <= count_r + CntW'(1);
    end
  end

  // scan address and read tag
  logic             eval_vld_r;
  logic [AddrW-1:0] eval_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      eval_vld_r <= 1'b0;
    end else begin
      eval_vld_r <= cmd.scan_step;
      if (cmd.start || cmd.emit) scan_idx_r <= '0;
      else if (cmd.scan_step) scan_idx_r <= scan_idx_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) eval_idx_r <= scan_idx_r[AddrW-1:0];
  end

  // service order key: phase bit, then cylinder in sweep direction
  logic [CylW-1:0] head_r;
  logic            cls;
  logic [CylW-1:0] kv;
  logic [KeyW-1:0] key;
  logic            have_best_r, have_last_r;
  logic [KeyW-1:0] best_key_r, last_key_r;
  logic [AddrW-1:0] best_idx_r, last_idx_r;
  logic [CylW-1:0] best_val_r;
  logic            after_last, better, take;

  assign cls        = sweep_right_r ? (rd_data_r <= head_r) : (rd_data_r > head_r);
  assign kv         = sweep_right_r ? rd_data_r : ~rd_data_r;
  assign key        = {cls, kv};
  assign after_last = !have_last_r || ({key, eval_idx_r} > {last_key_r, last_idx_r});
  assign better     = !have_best_r || (key < best_key_r);
  assign take       = eval_vld_r && after_last && better;

  // best candidate and last served entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      have_last_r <= 1'b0;
    end else begin
      if (cmd.start || cmd.emit) have_best_r <= 1'b0;
      else if (take) have_best_r <= 1'b1;
      if (cmd.start) have_last_r <= 1'b0;
      else if (cmd.emit) have_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_key_r <= key;
      best_val_r <= rd_data_r;
      best_idx_r <= eval_idx_r;
    end
    if (cmd.emit) begin
      last_key_r <= best_key_r;
      last_idx_r <= best_idx_r;
    end
    if (cmd.start) head_r <= head_clamp;
  end

  // head position and movement
  logic [SizeW-1:0] cur_r;
  logic [MoveW-1:0] move_r;
  logic             swept_r;
  logic [CntW-1:0]  emitted_r;
  logic [SizeW-1:0] best_ext, hop;

  assign best_ext = {1'b0, best_val_r};
  assign hop      = (best_ext > cur_r) ? (best_ext - cur_r) : (cur_r - best_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swept_r   <= 1'b0;
      emitted_r <= '0;
    end else if (cmd.start) begin
      swept_r   <= 1'b0;
      emitted_r <= '0;
    end else begin
      if (cmd.sweep_b) swept_r <= 1'b1;
      if (cmd.emit) emitted_r <= emitted_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_r  <= {1'b0, head_clamp};
      move_r <= '0;
    end else if (cmd.sweep_a) begin
      move_r <= move_r + MoveW'(sweep_right_r ? (top - cur_r) : cur_r);
    end else if (cmd.sweep_b) begin
      move_r <= move_r + MoveW'(top);
      cur_r  <= sweep_right_r ? '0 : top;
    end else if (cmd.emit) begin
      move_r <= move_r + MoveW'(hop);
      cur_r  <= best_ext;
    end
  end

  // result register
  logic             out_valid_r;
  logic             out_kind_r, out_end_r;
  logic [CylW-1:0]  out_cyl_r;
  logic [MoveW-1:0] out_move_r;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.summary) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= KIND_SERVED;
      out_cyl_r  <= best_val_r;
      out_move_r <= '0;
      out_end_r  <= 1'b0;
    end else if (cmd.summary) begin
      out_kind_r <= KIND_SUMMARY;
      out_cyl_r  <= '0;
      out_move_r <= move_r;
      out_end_r  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_cyl   = out_cyl_r;
  assign out_move  = out_move_r;
  assign out_end   = out_end_r;

  // status
  assign stat.in_valid    = in_valid;
  assign stat.in_last     = in_last;
  assign stat.scan_last   = (scan_idx_r == (count_r - CntW'(1)));
  assign stat.best_cls    = best_key_r[KeyW-1];
  assign stat.swept       = swept_r;
  assign stat.emitted_all = (emitted_r == count_r);
  assign stat.emit_last   = (emitted_r == (count_r - CntW'(1)));
  assign stat.out_free    = out_free;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntMax) else $error("request count above store depth");
  a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> have_best_r) else $error("emit without a scan candidate");
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.summary) |-> out_free) else $error("result register overwritten");
  a_summary_swept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.summary |-> (swept_r && (emitted_r == count_r))) else $error("summary before sweep");
  a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.summary |=> (count_r == '0)) else $error("batch not cleared after summary");
`endif

endmodule

FILE: rtl/cscan_disk_scheduler.sv
// loading: one request beat per cycle while idle; the beat marked last starts the run
// run: the stored requests are served one by one and a summary beat ends the run; result stalls hold it up
// each served result needs one full scan of the request store (one read port, one entry a cycle)
// output register lets the next result be prepared while one waits to be taken
// reset (rst_n low, synchronous): batch emptied, disk_size 200, start_head 0, sweep right
module cscan_disk_scheduler import csd_pkg::*; #(
  parameter int MAX_REQUESTS  = 32,
  parameter int CYLINDER_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  csd_req_if.sink  in_req,
  csd_res_if.source out_res,
  csd_cfg_if.sink  cfg_wr
);

  csd_cmd_t  cmd;
  csd_stat_t stat;

  // controller
  csd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  csd_dp #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (in_req.valid),
    .in_cyl    (in_req.request_cylinder),
    .in_last   (in_req.last_request),
    .cfg_valid (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .out_kind  (out_res.result_kind),
    .out_cyl   (out_res.served_cylinder),
    .out_move  (out_res.total_movement),
    .out_end   (out_res.end_of_run)
  );

  // handshake readiness
  assign in_req.ready = cmd.take_req;
  assign cfg_wr.ready = 1'b1;

endmodule

FILE: tb/cscan_order_checker.sv
module cscan_order_checker import csd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  csd_req_if   req,
  csd_res_if   res,
  csd_cfg_if   cfg,
  output int   failures,
  output int   pending
);

  localparam int MaxReq = 32;

  typedef struct packed {
    logic             kind;
    logic [CylW-1:0]  cyl;
    logic [MoveW-1:0] move;
    logic             last;
  } served_t;

  // mirror of the configuration registers
  logic [SizeW-1:0] disk_size;
  logic [CylW-1:0]  start_head;
  logic             sweep_right;

  // pending batch of requests
  int unsigned batch_store [MaxReq];
  int          batch_len;

  // expected service order, oldest first
  served_t order_q [$];
  served_t want;
  served_t got;

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic flag_mismatch(input string what, input int unsigned seen,
                               input int unsigned wanted);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, seen, wanted);
    failures++;
  endtask

  // disk size after the zero and oversize corrections
  function automatic int unsigned usable_size();
    int unsigned s;
    s = disk_size;
    if (s == 0) s = 1;
    if (s > (1 << CylW)) s = 1 << CylW;
    return s;
  endfunction

  function automatic int unsigned span(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void push_served(input int unsigned cyl);
    order_q.push_back('{KIND_SERVED, cyl[CylW-1:0], '0, 1'b0});
  endfunction

  // sort the batch and build the c-scan service order with its total travel
  function automatic void schedule_batch();
    int unsigned sorted [MaxReq];
    int unsigned v, head, top, move;
    int          n, split, i, j;
    top = usable_size() - 1;
    n   = batch_len;
    for (i = 0; i < n; i++) begin
      v = batch_store[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    head = start_head;
    if (head > top) head = top;
    // first request strictly above the head, or past the end if none
    split = n;
    for (i = 0; i < n; i++) begin
      if (sorted[i] > head) begin
        split = i;
        break;
      end
    end
    move = 0;
    if (sweep_right) begin
      for (i = split; i < n; i++) begin
        move += span(sorted[i], head);
        head = sorted[i];
        push_served(head);
      end
      move += (top - head) + top;
      head = 0;
      for (i = 0; i < split; i++) begin
        move += span(sorted[i], head);
        head = sorted[i];
        push_served(head);
      end
    end else begin
      for (i = split; i > 0; i--) begin
        move += span(sorted[i-1], head);
        head = sorted[i-1];
        push_served(head);
      end
      move += head + top;
      head = top;
      for (i = n; i > split; i--) begin
        move += span(sorted[i-1], head);
        head = sorted[i-1];
        push_served(head);
      end
    end
    order_q.push_back('{KIND_SUMMARY, '0, move[MoveW-1:0], 1'b1});
  endfunction

  // one request beat: clamp, store while room is left, schedule on the last one
  function automatic void take_request(input logic [CylW-1:0] cyl, input logic last);
    int unsigned top, c;
    top = usable_size() - 1;
    c   = cyl;
    if (c > top) c = top;
    if (batch_len < MaxReq) begin
      batch_store[batch_len] = c;
      batch_len++;
    end
    if (last) begin
      schedule_batch();
      batch_len = 0;
    end
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      disk_size   = 200;
      start_head  = '0;
      sweep_right = 1'b1;
      batch_len   = 0;
      order_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_DISK_SIZE:   disk_size   = cfg.data[SizeW-1:0];
          CFG_START_HEAD:  start_head  = cfg.data[CylW-1:0];
          CFG_SWEEP_RIGHT: sweep_right = cfg.data[0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) take_request(req.request_cylinder, req.last_request);
      if (res.valid && res.ready) begin
        got = '{res.result_kind, res.served_cylinder, res.total_movement, res.end_of_run};
        if (order_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected, cylinder", got.cyl, 0);
        end else begin
          want = order_q.pop_front();
          if (got.kind !== want.kind) flag_mismatch("result_kind", got.kind, want.kind);
          if (got.cyl !== want.cyl) flag_mismatch("served_cylinder", got.cyl, want.cyl);
          if (got.move !== want.move) flag_mismatch("total_movement", got.move, want.move);
          if (got.last !== want.last) flag_mismatch("end_of_run", got.last, want.last);
        end
      end
    end
    pending <= order_q.size();
  end

endmodule

FILE: tb/cscan_disk_scheduler_tb.sv
module cscan_disk_scheduler_tb;
  import csd_pkg::*;

  localparam int WatchdogLimit = 5000;

  logic clk;
  logic rst_n;
  int   failures;
  int   pending;
  int   send_idle_pct;
  int   stall_pct;
  int   idle_cycles;

  // what the stimulus assumes about the current setting
  int unsigned cur_size;
  int unsigned cur_head;

  logic [CylW-1:0] batch_q [$];

  csd_req_if req_if ();
  csd_res_if res_if ();
  csd_cfg_if cfg_if ();

  cscan_disk_scheduler u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  cscan_order_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_if),
    .res      (res_if),
    .cfg      (cfg_if),
    .failures (failures),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // give up after a long stretch with no beat on any channel
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request beat, with random gaps in front of it
  task automatic send_request(input logic [CylW-1:0] cyl, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid            <= 1'b1;
    req_if.request_cylinder <= cyl;
    req_if.last_request     <= last;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_batch();
    for (int i = 0; i < batch_q.size(); i++) send_request(batch_q[i], i == batch_q.size() - 1);
  endtask

  // stop sending until the service order has drained, then let the block settle
  task automatic settle(input int extra);
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_disk(input int unsigned size, input int unsigned head, input logic right);
    settle(8);
    write_reg(CFG_DISK_SIZE, size[CfgDataW-1:0]);
    write_reg(CFG_START_HEAD, head[CfgDataW-1:0]);
    write_reg(CFG_SWEEP_RIGHT, {16'd0, right});
    cfg_if.valid <= 1'b0;
    cur_size = (size == 0) ? 1 : (size > 65536) ? 65536 : size;
    cur_head = head;
  endtask

  // random requests, mostly on the disk, some clamped, some repeated or near the head
  task automatic random_batch(input int len);
    int unsigned v;
    v = 0;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: v = $urandom_range(65535);
        1: v = $urandom_range(1) ? cur_size - 1 : 0;
        2: v = (cur_head + $urandom_range(4) >= 2) ? cur_head + $urandom_range(4) - 2 : 0;
        3: ;
        default: v = $urandom_range(cur_size - 1);
      endcase
      send_request(v[CylW-1:0], i == len - 1);
    end
  endtask

  initial begin
    int          phase_items;
    int          len;
    int unsigned size;
    logic        first;
    rst_n                   = 1'b0;
    req_if.valid            = 1'b0;
    req_if.request_cylinder = '0;
    req_if.last_request     = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = '0;
    cfg_if.data             = '0;
    res_if.ready            = 1'b0;
    idle_cycles             = 0;
    send_idle_pct           = 0;
    stall_pct               = 0;
    cur_size                = 200;
    cur_head                = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: clamping of requests past the disk end
    batch_q = {16'd100, 16'd199, 16'd0, 16'd250, 16'd65535, 16'd50};
    send_batch();
    // one-cylinder disk, moving left
    set_disk(1, 0, 1'b0);
    batch_q = {16'd0, 16'd65535};
    send_batch();
    // zero disk size, head past the end
    set_disk(0, 65535, 1'b0);
    batch_q = {16'd7};
    send_batch();
    // oversize disk, request equal to the head
    set_disk(131071, 32768, 1'b0);
    batch_q = {16'd32768, 16'd0, 16'd65535, 16'd12345, 16'd43690, 16'd21845};
    send_batch();
    // nothing above the head
    set_disk(65536, 65535, 1'b1);
    batch_q = {16'd10, 16'd65535, 16'd300};
    send_batch();
    // moving left from the bottom
    set_disk(65536, 0, 1'b0);
    batch_q = {16'd5, 16'd0, 16'd9};
    send_batch();

    // random phases with different idling on both sides
    first = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      settle(8);
      send_idle_pct = (ph == 1) ? 54 : (ph == 3) ? 32 : 0;
      stall_pct    <= (ph == 2) ? 54 : (ph == 3) ? 32 : 0;
      phase_items = 0;
      while (phase_items < 40) begin
        case ($urandom_range(9))
          0:       size = 0;
          1:       size = $urandom_range(131071, 65537);
          2:       size = 65536;
          3, 4:    size = $urandom_range(16, 1);
          default: size = $urandom_range(65535, 17);
        endcase
        set_disk(size,
                 $urandom_range(4) == 0 ? $urandom_range(65535)
                   : $urandom_range((size == 0) ? 0 : (size > 65536) ? 65535 : size - 1),
                 $urandom_range(1));
        repeat ($urandom_range(4, 2)) begin
          case ($urandom_range(19))
            0:          len = $urandom_range(36, 33);
            1, 2, 3:    len = $urandom_range(32, 9);
            default:    len = $urandom_range(8, 1);
          endcase
          // open with an overfull batch: the beats past the store depth are not stored
          if (first) len = 34;
          first = 1'b0;
          random_batch(len);
          phase_items += len;
          if ($urandom_range(3) == 0) settle(0);
        end
      end
    end

    settle(50);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
